// ===== rtl/cpm_pkg.sv =====
// Shared constants, types and the parent-constraint builder for the
// Cartesian parent match counter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int PAT_BYTES = 16;
    localparam int WIN = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
    localparam int WIN_IDX_BITS = $clog2(WIN);
    localparam int FILL_BITS = $clog2(MAX_PATTERN + 1);
    localparam int LEN_BITS = 5;
    localparam int CMP_BITS = (FILL_BITS > LEN_BITS) ? FILL_BITS : LEN_BITS;
    localparam int COUNT_BITS = 32;
    localparam int OUT_COUNT_BITS = 32;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS = 2;
    localparam int BYTE_BITS = 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    // Relations required between window taps, indexed [child age][parent age].
    // le: parent <= child, lt: parent < child.
    typedef struct packed {
        logic                       len_ok;
        logic [WIN-1:0][WIN-1:0]    le;
        logic [WIN-1:0][WIN-1:0]    lt;
    } req_t;

    function automatic req_t build_req(
        input logic [CFG_DATA_BITS-1:0] lo,
        input logic [CFG_DATA_BITS-1:0] hi,
        input logic [LEN_BITS-1:0]      len
    );
        req_t                               r;
        logic [2*CFG_DATA_BITS-1:0]         pat;
        logic signed [BYTE_BITS-1:0]        p [WIN];
        logic                               lf;
        logic                               rf;
        logic [WIN_IDX_BITS-1:0]            li;
        logic [WIN_IDX_BITS-1:0]            ri;
        logic [WIN_IDX_BITS-1:0]            q;
        logic [LEN_BITS-1:0]                ca;
        logic [LEN_BITS-1:0]                pa;
        logic                               strict_rel;
        r.le = '0;
        r.lt = '0;
        r.len_ok = (len != '0) && (int'(len) <= WIN);
        pat = {hi, lo};
        for (int i = 0; i < WIN; i++) begin
            p[i] = pat[BYTE_BITS*i +: BYTE_BITS];
        end
        for (int i = 0; i < WIN; i++) begin
            lf = 1'b0;
            rf = 1'b0;
            li = '0;
            ri = '0;
            for (int j = 0; j < i; j++) begin
                if (p[j] <= p[i]) begin
                    lf = 1'b1;
                    li = WIN_IDX_BITS'(j);
                end
            end
            for (int k = WIN - 1; k > i; k--) begin
                if ((k < int'(len)) && (p[k] < p[i])) begin
                    rf = 1'b1;
                    ri = WIN_IDX_BITS'(k);
                end
            end
            // larger neighbor wins, ties go right
            if (lf && rf) begin
                strict_rel = !(p[li] > p[ri]);
                q = strict_rel ? ri : li;
            end else begin
                strict_rel = rf;
                q = rf ? ri : li;
            end
            if ((i < int'(len)) && (lf || rf)) begin
                ca = len - LEN_BITS'(1) - LEN_BITS'(i);
                pa = len - LEN_BITS'(1) - LEN_BITS'(q);
                if (strict_rel) begin
                    r.lt[ca[WIN_IDX_BITS-1:0]][pa[WIN_IDX_BITS-1:0]] = 1'b1;
                end else begin
                    r.le[ca[WIN_IDX_BITS-1:0]][pa[WIN_IDX_BITS-1:0]] = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cpm_if.sv =====
// Valid/ready channel interfaces for text beats, result beats and config writes.
// Depends on cpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cpm_text_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [cpm_pkg::BYTE_BITS-1:0]       text_byte;
    logic                                       is_last;
    modport source (output valid, text_byte, is_last, input ready);
    modport sink   (input valid, text_byte, is_last, output ready);
endinterface

interface cpm_result_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       window_match;
    logic [cpm_pkg::OUT_COUNT_BITS-1:0]         match_count;
    logic                                       text_done;
    modport source (output valid, window_match, match_count, text_done, input ready);
    modport sink   (input valid, window_match, match_count, text_done, output ready);
endinterface

interface cpm_cfg_if;
    logic                                       valid;
    logic                                       ready;
    logic [cpm_pkg::CFG_IDX_BITS-1:0]           index;
    logic [cpm_pkg::CFG_DATA_BITS-1:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cartesian_parent_match_counter_top.sv =====
// Cartesian parent match counter: top level. Depends on cpm_pkg and cpm_if.
// One text beat per cycle while not stalled; each beat gives exactly one result beat.
//
// Rate: one text beat per clock, sustained, whenever the result side takes beats.
// The path is registered: the window shift register, then the parallel compare of
// all window tap pairs against the registered parent-constraint table. After any
// config write the table is rebuilt, and text beats stall while the rebuild is pending.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_parent_match_counter_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cpm_text_if.sink    text_in,
    cpm_result_if.source result_out,
    cpm_cfg_if.sink     cfg
);

    localparam int W = cpm_pkg::WIN;

    logic [cpm_pkg::CFG_DATA_BITS-1:0]      pat_lo_reg;
    logic [cpm_pkg::CFG_DATA_BITS-1:0]      pat_hi_reg;
    logic [cpm_pkg::LEN_BITS-1:0]           pat_len_reg;
    logic                                   tbl_dirty_reg;
    cpm_pkg::req_t                          req_reg;

    logic signed [cpm_pkg::BYTE_BITS-1:0]   recent_reg [cpm_pkg::MAX_PATTERN];
    logic [cpm_pkg::FILL_BITS-1:0]          filled_reg;
    logic [cpm_pkg::FILL_BITS-1:0]          filled_next;
    logic                                   s1_valid_reg;
    logic                                   s1_full_reg;
    logic                                   s1_last_reg;

    logic                                   out_valid_reg;
    logic                                   out_match_reg;
    logic                                   out_done_reg;
    logic [cpm_pkg::COUNT_BITS-1:0]         count_reg;
    logic [cpm_pkg::COUNT_BITS-1:0]         count_next;

    logic                                   advance;
    logic                                   in_beat;
    logic                                   cfg_beat;
    logic                                   bad;
    logic                                   match;

    assign cfg.ready  = 1'b1;
    assign cfg_beat   = cfg.valid && cfg.ready;
    assign advance    = !out_valid_reg || result_out.ready;
    assign text_in.ready = advance && !tbl_dirty_reg;
    assign in_beat    = text_in.valid && text_in.ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg    <= '0;
            pat_hi_reg    <= '0;
            pat_len_reg   <= cpm_pkg::LEN_BITS'(1);
            tbl_dirty_reg <= 1'b1;
        end
        else
        begin
            tbl_dirty_reg <= cfg_beat;
            if (cfg_beat)
            begin
                unique case (cpm_pkg::cfg_reg_t'(cfg.index))
                    cpm_pkg::REG_PATTERN_LOW:    pat_lo_reg <= cfg.data;
                    cpm_pkg::REG_PATTERN_HIGH:   pat_hi_reg <= cfg.data;
                    cpm_pkg::REG_PATTERN_LENGTH: pat_len_reg <= cfg.data[cpm_pkg::LEN_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_dirty_reg)
        begin
            req_reg <= cpm_pkg::build_req(pat_lo_reg, pat_hi_reg, pat_len_reg);
        end
    end

    // stage 1: window shift register and fill count
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            recent_reg[0] <= text_in.text_byte;
            for (int k = 1; k < cpm_pkg::MAX_PATTERN; k++)
            begin
                recent_reg[k] <= recent_reg[k-1];
            end
            s1_last_reg <= text_in.is_last;
            s1_full_reg <= (cpm_pkg::CMP_BITS'(filled_next) >= cpm_pkg::CMP_BITS'(pat_len_reg));
        end
    end

    assign filled_next = (filled_reg == cpm_pkg::FILL_BITS'(cpm_pkg::MAX_PATTERN))
                       ? filled_reg : filled_reg + cpm_pkg::FILL_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                filled_reg <= text_in.is_last ? '0 : filled_next;
            end
            if (advance)
            begin
                s1_valid_reg <= in_beat;
            end
        end
    end

    // stage 2: pairwise tap compare against the constraint table
    always_comb
    begin
        bad = 1'b0;
        for (int c = 0; c < W; c++)
        begin
            for (int p = 0; p < W; p++)
            begin
                if (req_reg.le[c][p] && (recent_reg[p] > recent_reg[c]))
                begin
                    bad = 1'b1;
                end
                if (req_reg.lt[c][p] && !(recent_reg[p] < recent_reg[c]))
                begin
                    bad = 1'b1;
                end
            end
        end
    end

    assign match = s1_full_reg && req_reg.len_ok && !bad;
    assign count_next = (match && !(&count_reg)) ? count_reg + cpm_pkg::COUNT_BITS'(1)
                                                  : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                count_reg <= s1_last_reg ? '0 : count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_match_reg            <= match;
            out_done_reg             <= s1_last_reg;
            result_out.match_count   <= cpm_pkg::OUT_COUNT_BITS'(count_next);
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.window_match = out_match_reg;
    assign result_out.text_done    = out_done_reg;

endmodule

`default_nettype wire

// ===== test/cpm_match_checker.sv =====
// Checker for the Cartesian parent match counter: watches config, text and result beats,
// predicts each result from its own copy of pattern and window state, and counts mismatches.
// Depends on cpm_pkg and the channel interfaces in cpm_if.
`timescale 1ns / 1ps

module cpm_match_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cpm_text_if         text_mon,
    cpm_result_if       result_mon,
    cpm_cfg_if          cfg_mon,
    output int          errors,
    output int          outstanding,
    output int          results_seen,
    output int          matches_seen
);
    import cpm_pkg::*;

    typedef struct packed {
        logic                       window_match;
        logic [OUT_COUNT_BITS-1:0]  match_count;
        logic                       text_done;
    } verdict_t;

    logic [CFG_DATA_BITS-1:0]       pat_lo;
    logic [CFG_DATA_BITS-1:0]       pat_hi;
    logic [LEN_BITS-1:0]            pat_len;
    logic signed [BYTE_BITS-1:0]    history [MAX_PATTERN];
    int                             fill;
    logic [COUNT_BITS-1:0]          run_count;
    verdict_t                       pending_q [$];

    // Cartesian-tree parents of the pattern via a monotone stack, then the parent
    // relations checked on the window; history[0] is the newest byte.
    function automatic logic window_fits();
        logic [2*CFG_DATA_BITS-1:0]     bits;
        logic signed [BYTE_BITS-1:0]    pat [PAT_BYTES];
        int                             up [PAT_BYTES];
        int                             chain [PAT_BYTES];
        int                             depth;
        int                             top;
        int                             dropped;
        int                             m;
        logic signed [BYTE_BITS-1:0]    child;
        logic signed [BYTE_BITS-1:0]    parent;
        logic                           fits;
        m = int'(pat_len);
        // bad length or short window never matches
        if (m < 1 || m > PAT_BYTES || m > MAX_PATTERN || fill < m)
            return 1'b0;
        bits = {pat_hi, pat_lo};
        for (int j = 0; j < PAT_BYTES; j++)
            pat[j] = bits[BYTE_BITS*j +: BYTE_BITS];
        depth = 0;
        for (int i = 0; i < m; i++)
        begin
            dropped = -1;
            top = -1;
            while (depth > 0)
            begin
                top = chain[depth-1];
                if (pat[top] <= pat[i])
                    break;
                depth--;
                dropped = top;
            end
            up[i] = (depth == 0) ? i : top;
            if (dropped >= 0)
                up[dropped] = i;
            chain[depth] = i;
            depth++;
        end
        fits = 1'b1;
        for (int i = 0; i < m; i++)
        begin
            child = history[m-1-i];
            parent = history[m-1-up[i]];
            if (up[i] < i && parent > child)
                fits = 1'b0;
            else if (up[i] > i && !(child > parent))
                fits = 1'b0;
        end
        return fits;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        verdict_t got;
        if (!rst_n)
        begin
            pat_lo = '0;
            pat_hi = '0;
            pat_len = LEN_BITS'(1);
            for (int k = 0; k < MAX_PATTERN; k++)
                history[k] = '0;
            fill = 0;
            run_count = '0;
            pending_q.delete();
            errors = 0;
            outstanding = 0;
            results_seen = 0;
            matches_seen = 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_reg_t'(cfg_mon.index))
                    REG_PATTERN_LOW:    pat_lo = cfg_mon.data;
                    REG_PATTERN_HIGH:   pat_hi = cfg_mon.data;
                    REG_PATTERN_LENGTH: pat_len = cfg_mon.data[LEN_BITS-1:0];
                    default: ;
                endcase
            end
            if (text_mon.valid && text_mon.ready)
            begin
                for (int k = MAX_PATTERN - 1; k > 0; k--)
                    history[k] = history[k-1];
                history[0] = text_mon.text_byte;
                if (fill < MAX_PATTERN)
                    fill++;
                want.window_match = window_fits();
                if (want.window_match && run_count != '1)
                    run_count++;
                want.match_count = OUT_COUNT_BITS'(run_count);
                want.text_done = text_mon.is_last;
                pending_q.push_back(want);
                if (text_mon.is_last)
                begin
                    run_count = '0;
                    fill = 0;
                end
            end
            if (result_mon.valid && result_mon.ready)
            begin
                got.window_match = result_mon.window_match;
                got.match_count = result_mon.match_count;
                got.text_done = result_mon.text_done;
                results_seen++;
                if (got.window_match === 1'b1)
                    matches_seen++;
                if (pending_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("checker: unexpected result beat match=%0b count=%0d done=%0b",
                                 got.window_match, got.match_count, got.text_done);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (got.window_match !== want.window_match
                        || got.match_count !== want.match_count
                        || got.text_done !== want.text_done)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("checker: beat %0d exp m=%0b c=%0d d=%0b got m=%0b c=%0d d=%0b",
                                     results_seen, want.window_match, want.match_count,
                                     want.text_done, got.window_match, got.match_count,
                                     got.text_done);
                    end
                end
            end
            outstanding = pending_q.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the Cartesian parent match counter: clock, reset, pattern writes,
// text beats with random gaps and output stalls, verdict. Depends on cpm_pkg, cpm_if,
// the block and cpm_match_checker.
`timescale 1ns / 1ps

module tb;
    import cpm_pkg::*;

    localparam int ITEM_TARGET  = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int { FULL_RANGE, EXTREMES, FEW_LEVELS } byte_mix_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    int     cycles = 0;
    int     errors;
    int     outstanding;
    int     results_seen;
    int     matches_seen;
    int     beats_sent = 0;
    int     settings_used = 0;
    bit     calm = 1'b0;
    bit     hold_req = 1'b0;
    bit     hold_done = 1'b0;

    logic signed [7:0]  pat_b [PAT_BYTES];
    logic [LEN_BITS-1:0] pat_len_cur;

    cpm_text_if     text_ch ();
    cpm_result_if   result_ch ();
    cpm_cfg_if      cfg_ch ();

    cartesian_parent_match_counter_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_ch),
        .result_out (result_ch),
        .cfg        (cfg_ch)
    );

    cpm_match_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .text_mon       (text_ch),
        .result_mon     (result_ch),
        .cfg_mon        (cfg_ch),
        .errors         (errors),
        .outstanding    (outstanding),
        .results_seen   (results_seen),
        .matches_seen   (matches_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[cartesian_parent_match_counter_top] ERROR");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [7:0] rand_byte(input byte_mix_t mix);
        int v;
        case (mix)
            FULL_RANGE: v = $urandom_range(0, 255);
            EXTREMES:
                case ($urandom_range(0, 4))
                    0: v = -128;
                    1: v = -1;
                    2: v = 0;
                    3: v = 1;
                    default: v = 127;
                endcase
            default: v = int'($urandom_range(0, 3)) - 2;
        endcase
        return 8'(v);
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(input logic signed [7:0] b, input logic last);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_ch.valid <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.is_last <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drain, then write all three registers from pat_b / pat_len_cur
    task automatic load_pattern();
        logic [2*CFG_DATA_BITS-1:0] bits;
        for (int j = 0; j < PAT_BYTES; j++)
            bits[8*j +: 8] = pat_b[j];
        text_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        write_reg(REG_PATTERN_LOW, bits[CFG_DATA_BITS-1:0]);
        write_reg(REG_PATTERN_HIGH, bits[2*CFG_DATA_BITS-1:CFG_DATA_BITS]);
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_BITS'(pat_len_cur));
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int stall;
        stall = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                stall--;
            end
            else if (!calm && $urandom_range(0, 99) < 25)
            begin
                result_ch.ready <= 1'b0;
                stall = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                   : $urandom_range(10, 40);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int                 phase;
        int                 n_texts;
        int                 text_len;
        int                 m;
        int                 minv;
        int                 maxv;
        int                 off;
        int                 r;
        bit                 leave_open;
        byte_mix_t          mix;
        logic signed [7:0]  text_q [$];

        text_ch.valid = 1'b0;
        text_ch.text_byte = '0;
        text_ch.is_last = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_PATTERN_LOW;
        cfg_ch.data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: length 1, every byte matches
        send_beat(8'h80, 1'b0);
        send_beat(8'h7F, 1'b1);

        // bad lengths never match
        for (int j = 0; j < PAT_BYTES; j++)
            pat_b[j] = '0;
        pat_len_cur = '0;
        load_pattern();
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        pat_len_cur = 5'd31;
        load_pattern();
        send_beat(8'h01, 1'b1);

        // full-length pattern with extremes and ties, text is the pattern itself
        pat_b = '{8'h7F, 8'h80, 8'h05, 8'h05, 8'hFD, 8'h7F, 8'h00, 8'h80,
                  8'h01, 8'h02, 8'h02, 8'hFF, 8'h40, 8'hC0, 8'h03, 8'h7F};
        pat_len_cur = 5'd16;
        load_pattern();
        for (int j = 0; j < PAT_BYTES; j++)
            send_beat(pat_b[j], 1'b0);

        // pattern swapped mid-text
        pat_b[0] = 8'hFB;
        pat_b[1] = 8'h05;
        pat_len_cur = 5'd2;
        load_pattern();
        send_beat(8'h0A, 1'b0);
        send_beat(8'h14, 1'b1);

        phase = 0;
        while (beats_sent < ITEM_TARGET)
        begin
            phase++;
            calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 3)
                pat_len_cur = '0;
            else if (r < 8)
                pat_len_cur = LEN_BITS'($urandom_range(17, 31));
            else if (r < 75)
                pat_len_cur = LEN_BITS'($urandom_range(1, 5));
            else
                pat_len_cur = LEN_BITS'($urandom_range(6, 16));
            mix = byte_mix_t'($urandom_range(0, 2));
            for (int j = 0; j < PAT_BYTES; j++)
                pat_b[j] = rand_byte(mix);
            load_pattern();
            if (phase == 4)
                hold_req = 1'b1;

            m = int'(pat_len_cur);
            minv = 127;
            maxv = -128;
            for (int j = 0; j < m && j < PAT_BYTES; j++)
            begin
                if (int'(pat_b[j]) < minv)
                    minv = int'(pat_b[j]);
                if (int'(pat_b[j]) > maxv)
                    maxv = int'(pat_b[j]);
            end

            n_texts = $urandom_range(1, 4);
            for (int t = 0; t < n_texts; t++)
            begin
                text_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 24);
                mix = byte_mix_t'($urandom_range(0, 2));
                text_q.delete();
                while (text_q.size() < text_len)
                begin
                    if (m >= 1 && m <= PAT_BYTES && $urandom_range(0, 2) == 0)
                    begin
                        // shifted copy keeps the tree shape
                        off = -128 - minv + int'($urandom_range(0, 255 - (maxv - minv)));
                        for (int j = 0; j < m; j++)
                            text_q.push_back(8'(int'(pat_b[j]) + off));
                    end
                    else
                        text_q.push_back(rand_byte(mix));
                end
                leave_open = (t == n_texts - 1) && ($urandom_range(0, 4) == 0);
                for (int k = 0; k < text_q.size(); k++)
                    send_beat(text_q[k], (k == text_q.size() - 1) && !leave_open);
            end
        end

        text_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("tb: %0d text beats, %0d results checked, %0d matching windows",
                 beats_sent, results_seen, matches_seen);
        $display("tb: %0d pattern loads incl. bad lengths and mid-text swaps, %0d-cycle stall",
                 settings_used, HOLD_CYCLES);
        if (errors == 0)
            $display("[cartesian_parent_match_counter_top] OK");
        else
            $display("[cartesian_parent_match_counter_top] ERROR");
        $finish;
    end

endmodule

// ===== cartesian_parent_match_counter_top.f =====
rtl/cpm_pkg.sv
rtl/cpm_if.sv
rtl/cartesian_parent_match_counter_top.sv
test/cpm_match_checker.sv
test/tb.sv
